[design/ust_pkg.sv]
// Shared types and codes for the unordered set table.
package ust_pkg;

  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_FIND     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

[design/unordered_set_table_unit.sv]
// A miss scans every stored entry and a hit stops at its slot; the result then passes the done
// state into the output register. A remove that hits adds a move state before done.
// One item at a time: a new item is taken only once the previous one has left the done state.
// The next item is taken while the previous result waits in the output register.
// Reset clears the count, the control state and the output valid; entries are not cleared.
// Top level of the unordered set table: entry memory, scan sequencer and output register.
module unordered_set_table_unit
  import ust_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int InW        = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [InW-1:0] s_tdata,   // value (VALUE_WIDTH bits), zero padded
  input  logic [1:0]     s_tuser,   // op
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,   // position [6:0], count [13:7], zero padded
  output logic [2:0]     m_tuser    // found [0], status [2:1]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] mem_q;

  op_t                    op_q;
  logic [VALUE_WIDTH-1:0] val;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic [AW-1:0]          rd_idx;
  logic                   rd_vld;
  logic                   found;
  logic [CW-1:0]          slot;
  status_t                status;

  logic                   hit_now, miss_now, resolved;
  logic                   rd_en, mem_re, mem_we;
  logic [AW-1:0]          mem_ra, mem_wa;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic                   cnt_inc, cnt_dec;
  status_t                status_nx;
  logic                   out_free;

  // The read data of the slot issued in the previous cycle is compared here.
  assign hit_now  = rd_vld && (mem_q == val);
  assign miss_now = !rd_vld && (idx == count);
  assign resolved = hit_now || miss_now;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (resolved) begin
          state_next = (op_q == OP_REMOVE && hit_now) ? S_MOVE : S_DONE;
        end
      end
      S_MOVE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    rd_en     = 1'b0;
    mem_re    = 1'b0;
    mem_ra    = idx[AW-1:0];
    mem_we    = 1'b0;
    mem_wa    = count[AW-1:0];
    mem_wd    = val;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    status_nx = ST_OK;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: begin
        rd_en  = !resolved && (idx < count);
        mem_re = rd_en;
        if (resolved) begin
          unique case (op_q)
            OP_INSERT: begin
              if (!hit_now) begin
                if (count < CW'(CAPACITY)) begin
                  mem_we  = 1'b1;
                  cnt_inc = 1'b1;
                end else begin
                  status_nx = ST_FULL;
                end
              end
            end
            OP_REMOVE: begin
              if (hit_now) begin
                // Fetch the last used entry; it fills the hole next cycle.
                mem_re = 1'b1;
                mem_ra = AW'(count - CW'(1));
              end else begin
                status_nx = ST_NOT_FOUND;
              end
            end
            default: status_nx = ST_OK;
          endcase
        end
      end
      S_MOVE: begin
        mem_we  = 1'b1;
        mem_wa  = slot[AW-1:0];
        mem_wd  = mem_q;
        cnt_dec = 1'b1;
      end
      S_DONE: s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) count <= count + CW'(1);
      if (cnt_dec) count <= count - CW'(1);
      if (state == S_IDLE) begin
        rd_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_vld <= rd_en;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      op_q <= op_t'(s_tuser);
      val  <= s_tdata[VALUE_WIDTH-1:0];
      idx  <= '0;
    end
    if (state == S_SCAN) begin
      rd_idx <= idx[AW-1:0];
      if (rd_en) idx <= idx + CW'(1);
      if (resolved) begin
        found  <= hit_now;
        slot   <= hit_now ? CW'(rd_idx) : count;
        status <= status_nx;
      end
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {2'b00, POS_W'(count), POS_W'(slot)};
      m_tuser <= {status, found};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_MOVE))
    else $error("entry write outside scan or move");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && count != $past(count)) |->
      ($past(state) == S_SCAN || $past(state) == S_MOVE))
    else $error("count changed outside an update");

endmodule

[verif/tb.sv]
// Self-checking testbench for the unordered set table: predicted results, random stimulus and stalls.
module tb;
  import ust_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP       = 64;
  localparam int POOL_SIZE = 96;
  localparam int RAND_ITEMS = 530;

  typedef struct packed {
    logic       found;
    logic [6:0] position;
    logic [6:0] count;
    status_t    status;
  } set_result_t;

  // Mirrors the set contents and queues the result each accepted item should produce.
  class set_scoreboard;
    logic [31:0] slot_val [CAP];
    int unsigned used;
    set_result_t expected_q [$];
    int unsigned n_noted, n_checked, n_errors;
    int unsigned n_full, n_dup, n_rm_hit, n_rm_miss, max_used;

    function void note_item(op_t op, logic [31:0] v);
      int unsigned k;
      int unsigned hit_at;
      bit hit;
      set_result_t r;
      hit = 1'b0;
      hit_at = used;
      for (k = 0; k < used; k++) begin
        if (!hit && slot_val[k] == v) begin
          hit = 1'b1;
          hit_at = k;
        end
      end
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (hit) begin
            n_dup++;
          end else if (used < CAP) begin
            slot_val[used] = v;
            used++;
          end else begin
            r.status = ST_FULL;
            n_full++;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            // The last used entry fills the hole left by the removed value.
            slot_val[hit_at] = slot_val[used-1];
            used--;
            n_rm_hit++;
          end else begin
            r.status = ST_NOT_FOUND;
            n_rm_miss++;
          end
        end
        default: ;
      endcase
      if (used > max_used) max_used = used;
      r.found = hit;
      r.position = 7'(hit_at);
      r.count = 7'(used);
      expected_q.push_back(r);
      n_noted++;
    endfunction

    function void check_result(logic found, logic [6:0] position, logic [6:0] count,
                               logic [1:0] status);
      set_result_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, found %0d position %0d count %0d status %0d",
                 $time, found, position, count, status);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (found !== e.found) begin
        $display("%0t: found mismatch, expected %0d, got %0d", $time, e.found, found);
        n_errors++;
      end
      if (position !== e.position) begin
        $display("%0t: position mismatch, expected %0d, got %0d", $time, e.position, position);
        n_errors++;
      end
      if (count !== e.count) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, e.count, count);
        n_errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  set_scoreboard sb = new;
  bit          calm = 1'b0;
  logic [31:0] pool [POOL_SIZE];

  unordered_set_table_unit #(
    .CAPACITY(CAP),
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser[0], m_tdata[6:0], m_tdata[13:7], m_tuser[2:1]);
    end
  end

  // Result side: random stalls plus one long hold-off that backs the block up.
  initial begin : result_sink
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.n_checked >= 120) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] v);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, v);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic op_t pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_INSERT;
    if (r < 60) return OP_REMOVE;
    if (r < 80) return OP_CONTAINS;
    return OP_FIND;
  endfunction

  // Mostly values from a shared pool so that hits are common; the rest exercise every bit.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return pool[$urandom_range(POOL_SIZE-1)];
    if (r < 90) return $urandom;
    if (r < 95) return 32'h1 << $urandom_range(31);
    return ~(32'h1 << $urandom_range(31));
  endfunction

  task automatic run_mixed(int unsigned n, int unsigned calm_from, int unsigned calm_to);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      calm = (i >= calm_from && i < calm_to);
      send_item(pick_op(), pick_value());
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned k;
    logic [31:0] v;

    pool[0] = '0;
    pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store, extremes, duplicate, lookups, and removes that move the last entry.
    send_item(OP_REMOVE,   32'h0000_0005);
    send_item(OP_CONTAINS, 32'h0000_0000);
    send_item(OP_FIND,     32'hFFFF_FFFF);
    send_item(OP_INSERT,   32'h0000_0000);
    send_item(OP_INSERT,   32'hFFFF_FFFF);
    send_item(OP_INSERT,   32'h0000_0000);
    send_item(OP_INSERT,   32'h8000_0001);
    send_item(OP_INSERT,   32'h7FFF_FFFE);
    send_item(OP_CONTAINS, 32'hFFFF_FFFF);
    send_item(OP_FIND,     32'h7FFF_FFFE);
    send_item(OP_FIND,     32'h0001_2345);
    send_item(OP_REMOVE,   32'h0000_0000);
    send_item(OP_FIND,     32'h7FFF_FFFE);
    send_item(OP_REMOVE,   32'h0000_0000);
    send_item(OP_REMOVE,   32'h8000_0001);
    send_item(OP_REMOVE,   32'hFFFF_FFFF);
    send_item(OP_REMOVE,   32'h7FFF_FFFE);
    send_item(OP_INSERT,   32'hA5A5_5A5A);

    run_mixed(180, 40, 110);

    // Sender pauses until the block has delivered everything outstanding.
    wait_all_results();

    // Fill to capacity, push against the full store, look up values, then empty it again.
    k = $urandom_range(POOL_SIZE-1);
    while (sb.used < CAP) begin
      v = (k < POOL_SIZE) ? pool[k] : $urandom;
      send_item(OP_INSERT, v);
      k++;
    end
    for (i = 0; i < 6; i++) begin
      v = (i % 2 == 0) ? $urandom : sb.slot_val[$urandom_range(CAP-1)];
      send_item(OP_INSERT, v);
    end
    for (i = 0; i < 8; i++) begin
      v = (i % 2 == 0) ? sb.slot_val[$urandom_range(CAP-1)] : $urandom;
      send_item((i % 4 < 2) ? OP_CONTAINS : OP_FIND, v);
    end
    while (sb.used != 0) begin
      if ($urandom_range(9) == 0) begin
        send_item(OP_REMOVE, $urandom);
      end else begin
        send_item(OP_REMOVE, sb.slot_val[$urandom_range(sb.used-1)]);
      end
    end

    if (sb.n_noted < RAND_ITEMS + 18) run_mixed(RAND_ITEMS + 18 - sb.n_noted, 0, 0);

    wait_all_results();
    repeat (CAP + 8) @(posedge clk);

    $display("Run covered %0d items: %0d full inserts, %0d duplicate inserts, %0d removes hit,",
             sb.n_noted, sb.n_full, sb.n_dup, sb.n_rm_hit);
    $display("%0d removes missed, peak occupancy %0d; %0d results checked, %0d mismatches.",
             sb.n_rm_miss, sb.max_used, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
